// ----- hdl/bounded_vector_engine_core_assert.svh -----
// Assertion macros used by the vector engine controller.
`ifndef BOUNDED_VECTOR_ENGINE_CORE_ASSERT_SVH
`define BOUNDED_VECTOR_ENGINE_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define BVE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Condition that must hold on every rising clock edge outside reset.
`define BVE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`endif

// ----- hdl/bve_pkg.sv -----
package bve_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  localparam logic [3:0] ReqPush   = 4'd0;
  localparam logic [3:0] ReqInsert = 4'd1;
  localparam logic [3:0] ReqEraseAt = 4'd2;
  localparam logic [3:0] ReqEraseVal = 4'd3;
  localparam logic [3:0] ReqEraseIf = 4'd4;
  localparam logic [3:0] ReqResize = 4'd5;
  localparam logic [3:0] ReqClear  = 4'd6;
  localparam logic [3:0] ReqPop    = 4'd7;
  localparam logic [3:0] ReqSort   = 4'd8;
  localparam logic [3:0] ReqRead   = 4'd9;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StPos   = 2'd2;
  localparam logic [1:0] StEmpty = 2'd3;

  // Datapath operations driven by the controller.
  typedef enum logic [2:0] {
    OpNone,
    OpRead,      // rd address -> read register
    OpWrite,     // write wr data at wr address
    OpCompact,   // conditional write of the read word at the compaction pointer
    OpMove       // write the read word at the wr address
  } bve_op_e;

  typedef struct packed {
    bve_op_e            op;
    logic [AddrW-1:0]   rd_addr;
    logic [AddrW-1:0]   wr_addr;
    logic               wr_zero;   // write zero instead of the input value
    logic               wr_tmp;    // write the held sort key word
    logic               load_tmp;  // capture read word as sort key word
  } bve_cmd_t;

  typedef struct packed {
    logic        rd_drop;   // read word matches erase criterion
    logic        rd_gt_tmp; // read word key above held key
    logic [31:0] rd_word;   // read word as seen by the current mode
  } bve_stat_t;

  function automatic logic [31:0] sext8(input logic [31:0] w);
    return {{24{w[7]}}, w[7:0]};
  endfunction

  function automatic logic vowel_hit(input logic [7:0] b);
    return b == 8'h61 || b == 8'h65 || b == 8'h69 || b == 8'h6f || b == 8'h75 ||
           b == 8'h79 || b == 8'h41 || b == 8'h45 || b == 8'h49 || b == 8'h4f ||
           b == 8'h55 || b == 8'h59;
  endfunction

endpackage

// ----- hdl/bounded_vector_engine_core.sv -----
// Ordered vector store of up to 64 signed 32-bit elements.
// Input channel: in_valid_i / in_stall_o with req_type_i, position_i, value_i.
// Output channel: out_valid_o / out_stall_i with status_o, count_o, element_o,
// removed_o; one result beat per request, held stable while stalled.
// Configuration: APB register 0 (byte address 0) holds element_mode.
// Clear, pop, shrinking resize and rejected requests go from idle straight to the
// result; push and insert shift the tail up one word at a time; erase walks read
// and compact the tail; zero fill writes one word at a time; read goes through the
// read register; sort is insertion sort, comparing and moving one word at a time.
// One request is handled at a time; the next is taken once the result has left.
// Reset empties the store (count zero) and sets integer mode.
// A stall on the output holds the result and holds off new requests.
module bounded_vector_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  req_type_i,
  input  logic [6:0]  position_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [6:0]  count_o,
  output logic [31:0] element_o,
  output logic [6:0]  removed_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               mode_q;
  logic [31:0]        val_q;
  logic               is_ev;
  bve_pkg::bve_cmd_t  cmd;
  bve_pkg::bve_stat_t stat;

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      mode_q <= pwdata[0];
    end
  end
  assign pready = 1'b1;
  assign prdata = {31'd0, mode_q};

  // Hold the value of the accepted beat for the whole request.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      val_q <= value_i;
    end
  end

  bve_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i, .position_i,
    .out_valid_o, .out_stall_i, .status_o, .count_o, .element_o, .removed_o,
    .is_erase_val_o(is_ev), .cmd_o(cmd), .stat_i(stat)
  );

  bve_datapath u_dp (
    .clk_i, .mode_i(mode_q), .is_erase_val_i(is_ev), .value_i(val_q),
    .cmd_i(cmd), .stat_o(stat)
  );

endmodule

// ----- hdl/bve_datapath.sv -----
module bve_datapath (
  input  logic                clk_i,
  input  logic                mode_i,
  input  logic                is_erase_val_i,
  input  logic [31:0]         value_i,
  input  bve_pkg::bve_cmd_t   cmd_i,
  output bve_pkg::bve_stat_t  stat_o
);

  logic [31:0] mem [bve_pkg::Capacity];
  logic [31:0] rd_q;
  logic [31:0] tmp_q;
  logic [31:0] wdata;
  logic [31:0] rd_view, tmp_view, val_view;
  logic        wen;

  // Choose the word to write.
  always_comb begin
    wen   = 1'b0;
    wdata = rd_q;
    unique case (cmd_i.op)
      bve_pkg::OpWrite: begin
        wen = 1'b1;
        if (cmd_i.wr_zero) begin
          wdata = '0;
        end else if (cmd_i.wr_tmp) begin
          wdata = tmp_q;
        end else begin
          wdata = mode_i ? bve_pkg::sext8(value_i) : value_i;
        end
      end
      bve_pkg::OpCompact: wen = !stat_o.rd_drop;
      bve_pkg::OpMove:    wen = 1'b1;
      default:            wen = 1'b0;
    endcase
  end

  // Store and registered read.
  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem[cmd_i.wr_addr] <= wdata;
    end
    rd_q <= mem[cmd_i.rd_addr];
    if (cmd_i.load_tmp) begin
      tmp_q <= mem[cmd_i.rd_addr];
    end
  end

  // Compare under the current mode, in signed order.
  assign rd_view  = mode_i ? bve_pkg::sext8(rd_q) : rd_q;
  assign tmp_view = mode_i ? bve_pkg::sext8(tmp_q) : tmp_q;
  assign val_view = mode_i ? bve_pkg::sext8(value_i) : value_i;

  assign stat_o.rd_word   = rd_view;
  assign stat_o.rd_gt_tmp = $signed(rd_view) > $signed(tmp_view);
  assign stat_o.rd_drop   = is_erase_val_i ? (rd_view == val_view)
                          : (mode_i ? bve_pkg::vowel_hit(rd_q[7:0]) : !rd_q[0]);

endmodule

// ----- hdl/bve_ctrl.sv -----
`include "bounded_vector_engine_core_assert.svh"
module bve_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [3:0]               req_type_i,
  input  logic [6:0]               position_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic [6:0]               count_o,
  output logic [31:0]              element_o,
  output logic [6:0]               removed_o,
  output logic                     is_erase_val_o,
  output bve_pkg::bve_cmd_t        cmd_o,
  input  bve_pkg::bve_stat_t       stat_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHUP  = 3'd1;  // shift tail up
  localparam logic [2:0] S_SHDN  = 3'd2;  // shift tail down / compact
  localparam logic [2:0] S_FILL  = 3'd3;  // zero fill
  localparam logic [2:0] S_SORTO = 3'd4;  // sort: load key
  localparam logic [2:0] S_SORTI = 3'd5;  // sort: inner walk
  localparam logic [2:0] S_READ  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam int unsigned AW = bve_pkg::AddrW;
  localparam int unsigned CW = bve_pkg::CntW;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] i_q, i_d;     // walk index
  logic [CW-1:0] j_q, j_d;     // compaction / insertion index
  logic [CW-1:0] end_q, end_d;
  logic          pend_q, pend_d; // a read is in flight
  logic [3:0]    req_q, req_d;
  logic [1:0]    st_q, st_d;
  logic [31:0]   el_q, el_d;
  logic [6:0]    rm_q, rm_d;
  logic          ov_q, ov_d;

  assign in_stall_o     = state_q != S_IDLE || ov_q;
  assign out_valid_o    = ov_q;
  assign status_o       = st_q;
  assign count_o        = 7'(cnt_q);
  assign element_o      = el_q;
  assign removed_o      = rm_q;
  assign is_erase_val_o = req_q == bve_pkg::ReqEraseVal;

  always_comb begin
    logic [CW-1:0] pos;
    pos      = CW'(position_i);
    state_d  = state_q;
    cnt_d    = cnt_q;
    i_d      = i_q;
    j_d      = j_q;
    end_d    = end_q;
    pend_d   = 1'b0;
    req_d    = req_q;
    st_d     = st_q;
    el_d     = el_q;
    rm_d     = rm_q;
    ov_d     = ov_q && out_stall_i;
    cmd_o    = '0;
    cmd_o.op = bve_pkg::OpNone;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !ov_q) begin
          req_d = req_type_i;
          st_d  = bve_pkg::StOk;
          el_d  = '0;
          rm_d  = '0;
          state_d = S_OUT;
          unique case (req_type_i)
            bve_pkg::ReqPush, bve_pkg::ReqInsert: begin
              if (req_type_i == bve_pkg::ReqPush) pos = cnt_q;
              if (7'(position_i) > 7'(cnt_q) && req_type_i == bve_pkg::ReqInsert) begin
                st_d = bve_pkg::StPos;
              end else if (cnt_q >= CW'(bve_pkg::Capacity)) begin
                st_d = bve_pkg::StFull;
              end else begin
                i_d = cnt_q; j_d = pos; state_d = S_SHUP;
              end
            end
            bve_pkg::ReqEraseAt: begin
              if (7'(position_i) >= 7'(cnt_q)) st_d = bve_pkg::StPos;
              else begin
                i_d = pos + 1'b1; j_d = pos; end_d = cnt_q;
                rm_d = 7'd1; state_d = S_SHDN;
              end
            end
            bve_pkg::ReqEraseVal, bve_pkg::ReqEraseIf: begin
              i_d = '0; j_d = '0; end_d = cnt_q; state_d = S_SHDN;
            end
            bve_pkg::ReqResize: begin
              if (position_i > 7'(bve_pkg::Capacity)) st_d = bve_pkg::StPos;
              else if (pos < cnt_q) begin
                rm_d = 7'(cnt_q - pos); cnt_d = pos;
              end else begin
                i_d = cnt_q; end_d = pos; state_d = S_FILL;
              end
            end
            bve_pkg::ReqClear: begin
              rm_d = 7'(cnt_q); cnt_d = '0;
            end
            bve_pkg::ReqPop: begin
              if (cnt_q == '0) st_d = bve_pkg::StEmpty;
              else begin cnt_d = cnt_q - 1'b1; rm_d = 7'd1; end
            end
            bve_pkg::ReqSort: begin
              i_d = CW'(1); state_d = S_SORTO;
            end
            bve_pkg::ReqRead: begin
              if (7'(position_i) >= 7'(cnt_q)) st_d = bve_pkg::StPos;
              else begin
                cmd_o.op = bve_pkg::OpRead; cmd_o.rd_addr = AW'(pos);
                state_d = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      // Move one word up at a time: read i-1, then write at i.
      S_SHUP: begin
        if (i_q == j_q) begin
          cmd_o.op = bve_pkg::OpWrite; cmd_o.wr_addr = AW'(j_q);
          cnt_d = cnt_q + 1'b1; state_d = S_OUT;
        end else if (!pend_q) begin
          cmd_o.rd_addr = AW'(i_q - 1'b1); pend_d = 1'b1;
        end else begin
          cmd_o.op = bve_pkg::OpMove; cmd_o.wr_addr = AW'(i_q);
          i_d = i_q - 1'b1;
        end
      end
      // Walk reads from i, write survivors at j.
      S_SHDN: begin
        if (!pend_q) begin
          if (i_q >= end_q) begin
            if (req_q != bve_pkg::ReqEraseAt) rm_d = 7'(cnt_q - j_q);
            cnt_d = j_q; state_d = S_OUT;
          end else begin
            cmd_o.rd_addr = AW'(i_q); pend_d = 1'b1;
          end
        end else begin
          cmd_o.wr_addr = AW'(j_q);
          i_d = i_q + 1'b1;
          if (req_q == bve_pkg::ReqEraseAt) begin
            cmd_o.op = bve_pkg::OpMove; j_d = j_q + 1'b1;
          end else begin
            cmd_o.op = bve_pkg::OpCompact;
            if (!stat_i.rd_drop) j_d = j_q + 1'b1;
          end
        end
      end
      S_FILL: begin
        if (i_q >= end_q) begin
          cnt_d = end_q; state_d = S_OUT;
        end else begin
          cmd_o.op = bve_pkg::OpWrite; cmd_o.wr_zero = 1'b1;
          cmd_o.wr_addr = AW'(i_q); i_d = i_q + 1'b1;
        end
      end
      // Insertion sort: load key at i, walk j down.
      S_SORTO: begin
        if (i_q >= cnt_q) state_d = S_OUT;
        else begin
          cmd_o.rd_addr = AW'(i_q); cmd_o.load_tmp = 1'b1;
          j_d = i_q; state_d = S_SORTI;
        end
      end
      S_SORTI: begin
        if (!pend_q) begin
          if (j_q == '0) begin
            cmd_o.op = bve_pkg::OpWrite; cmd_o.wr_tmp = 1'b1;
            cmd_o.wr_addr = AW'(j_q); i_d = i_q + 1'b1; state_d = S_SORTO;
          end else begin
            cmd_o.rd_addr = AW'(j_q - 1'b1); pend_d = 1'b1;
          end
        end else if (stat_i.rd_gt_tmp) begin
          cmd_o.op = bve_pkg::OpMove; cmd_o.wr_addr = AW'(j_q);
          j_d = j_q - 1'b1;
        end else begin
          cmd_o.op = bve_pkg::OpWrite; cmd_o.wr_tmp = 1'b1;
          cmd_o.wr_addr = AW'(j_q); i_d = i_q + 1'b1; state_d = S_SORTO;
        end
      end
      S_READ: begin
        el_d = stat_i.rd_word; state_d = S_OUT;
      end
      S_OUT: begin
        ov_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
      req_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
      req_q   <= req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    j_q   <= j_d;
    end_q <= end_d;
    st_q  <= st_d;
    el_q  <= el_d;
    rm_q  <= rm_d;
  end

  `BVE_ASSERT_ALWAYS(a_cnt_cap, clk_i, rst_ni, cnt_q <= CW'(bve_pkg::Capacity))
  `BVE_ASSERT_IMP(a_busy_no_out, clk_i, rst_ni, state_q != S_IDLE, !ov_q)
  `BVE_ASSERT_IMP(a_out_from_done, clk_i, rst_ni, $rose(ov_q), $past(state_q) == S_OUT)

endmodule
